[design/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, codes and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int CNT_BITS  = 33;
    localparam int MAX_BITS  = 32;
    localparam int SUM_BITS  = ((SIZE_BITS > CNT_BITS) ? SIZE_BITS : CNT_BITS) + 1;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_EXT     = 3'd1,
        PH_SIZE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATA_CR = 3'd4,
        PH_DATA_LF = 3'd5,
        PH_TRAILER = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_DONE     = 3'd1,
        ST_BAD_SIZE = 3'd2,
        ST_UNTERM   = 3'd3,
        ST_LIMIT    = 3'd4,
        ST_TRUNC    = 3'd5
    } t_status;

    // Trailer CRLFCRLF tracking: count of terminator bytes seen so far
    typedef enum logic [1:0] {
        TM_NONE = 2'd0,
        TM_CR1  = 2'd1,
        TM_LF1  = 2'd2,
        TM_CR2  = 2'd3
    } t_trail;

    typedef struct packed {
        logic       eos;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        t_status    status;
    } t_result;

    // Bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[design/cbd_in_reg.sv]
// ----------------------------------------------------------------------------
// cbd_in_reg
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module cbd_in_reg
    import cbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[design/cbd_engine.sv]
// ----------------------------------------------------------------------------
// cbd_engine
// Chunk framing state machine, size and byte counters, limit register.
// Produces one result per consumed byte.
// ----------------------------------------------------------------------------
module cbd_engine
    import cbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [MAX_BITS-1:0] i_cfg_wr_data,
    input  logic                i_step,
    input  t_item               i_item,
    output t_result             o_result
);

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_size, n_size;
    logic [SIZE_BITS-1:0]   r_rem, n_rem;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic                   r_saw, n_saw;
    t_trail                 r_tm, n_tm;
    t_status                r_status, n_status;
    logic [MAX_BITS-1:0]    r_max;

    logic [4:0]             hex;
    logic [SUM_BITS-1:0]    total;
    logic                   over_limit;

    assign hex        = hex_digit(i_item.data_byte);
    assign total      = SUM_BITS'(r_cnt) + SUM_BITS'(r_size);
    assign over_limit = total > SUM_BITS'(r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '1;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIZE;
            r_size   <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_saw    <= 1'b0;
            r_tm     <= TM_NONE;
            r_status <= ST_RUN;
        end else begin
            r_phase  <= n_phase;
            r_size   <= n_size;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_saw    <= n_saw;
            r_tm     <= n_tm;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_size   = r_size;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_saw    = r_saw;
        n_tm     = r_tm;
        n_status = r_status;
        o_result.body_valid = 1'b0;
        o_result.body_byte  = 8'd0;

        if (i_step && r_status == ST_RUN) begin
            if (i_item.eos) begin
                n_status = ST_TRUNC;
            end else begin
                case (r_phase)
                    PH_SIZE: begin
                        if (hex[4]) begin
                            // drop the size line once a further digit would overflow
                            if (r_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                                n_status = ST_BAD_SIZE;
                            end else begin
                                n_size = {r_size[SIZE_BITS-5:0], hex[3:0]};
                                n_saw  = 1'b1;
                            end
                        end else if (i_item.data_byte == CH_SEMI && r_saw) begin
                            n_phase = PH_EXT;
                        end else if (i_item.data_byte == CH_CR && r_saw) begin
                            n_phase = PH_SIZE_LF;
                        end else begin
                            n_status = ST_BAD_SIZE;
                        end
                    end
                    PH_EXT: begin
                        if (i_item.data_byte == CH_CR) begin
                            n_phase = PH_SIZE_LF;
                        end
                    end
                    PH_SIZE_LF: begin
                        if (i_item.data_byte != CH_LF) begin
                            n_status = ST_BAD_SIZE;
                        end else if (r_size == '0) begin
                            // last chunk: its CRLF already counts toward CRLFCRLF
                            n_phase = PH_TRAILER;
                            n_tm    = TM_LF1;
                        end else if (over_limit) begin
                            n_status = ST_LIMIT;
                        end else begin
                            n_rem   = r_size;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        o_result.body_valid = 1'b1;
                        o_result.body_byte  = i_item.data_byte;
                        n_cnt = r_cnt + CNT_BITS'(1);
                        n_rem = r_rem - SIZE_BITS'(1);
                        if (r_rem == SIZE_BITS'(1)) begin
                            n_phase = PH_DATA_CR;
                        end
                    end
                    PH_DATA_CR: begin
                        if (i_item.data_byte == CH_CR) begin
                            n_phase = PH_DATA_LF;
                        end else begin
                            n_status = ST_UNTERM;
                        end
                    end
                    PH_DATA_LF: begin
                        if (i_item.data_byte == CH_LF) begin
                            n_phase = PH_SIZE;
                            n_size  = '0;
                            n_saw   = 1'b0;
                        end else begin
                            n_status = ST_UNTERM;
                        end
                    end
                    PH_TRAILER: begin
                        if (i_item.data_byte == CH_CR) begin
                            n_tm = (r_tm == TM_LF1) ? TM_CR2 : TM_CR1;
                        end else if (i_item.data_byte == CH_LF) begin
                            if (r_tm == TM_CR2) begin
                                n_status = ST_DONE;
                                n_tm     = TM_NONE;
                            end else begin
                                n_tm = (r_tm == TM_CR1) ? TM_LF1 : TM_NONE;
                            end
                        end else begin
                            n_tm = TM_NONE;
                        end
                    end
                    default: begin
                        n_phase = PH_SIZE;
                        n_size  = '0;
                        n_saw   = 1'b0;
                    end
                endcase
            end
        end

        o_result.status = n_status;
    end

endmodule

[design/cbd_out_reg.sv]
// ----------------------------------------------------------------------------
// cbd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cbd_out_reg
    import cbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[design/chunked_body_decoder_core.sv]
// ----------------------------------------------------------------------------
// chunked_body_decoder_core
// Decodes a chunked transfer body byte by byte into payload bytes and status.
//
//   channel   direction  tdata                              tuser / tlast
//   s_axis    in         [7:0] data_byte                    tlast: end_of_stream
//   m_axis    out        [7:0] body_byte, [10:8] status     tuser: body_valid
//   cfg       in         i_cfg_wr_data: payload_limit       -
//
// One byte per cycle sustained while m_axis is ready; each transfer gives exactly
// one result. Path: input register, then parser into the result register.
// A stall on m_axis holds the result register and backs up through the
// input register to s_axis_tready.
// Reset clears the framing state, counters and status; the limit resets to
// all ones.
// ----------------------------------------------------------------------------
module chunked_body_decoder_core
    import cbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [MAX_BITS-1:0] i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [7:0] body_byte, [10:8] status
    output logic                m_axis_tuser    // [0] body_valid
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    can_load;
    t_result next_result;
    t_result out_result;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.eos       = s_axis_tlast;
    assign advance           = held_valid && can_load;

    cbd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    cbd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_item        (held_item),
        .o_result      (next_result)
    );

    cbd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (next_result),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {5'd0, out_result.status, out_result.body_byte};
    assign m_axis_tuser = out_result.body_valid;

endmodule
